### design/tsce_pkg.sv
// Shared types and constants of the text screen cursor engine.
package tsce_pkg;

	localparam int ROWS_DEF   = 2;
	localparam int COLS_DEF   = 16;
	localparam int ROW_W      = 2;
	localparam int COL_W      = 5;
	localparam int CHAR_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	typedef enum logic [3:0] {
		CMD_PUT, CMD_GOTO, CMD_HOME, CMD_CLEAR, CMD_CLRLINE, CMD_CLRCOLS, CMD_BKSP, CMD_TAB,
		CMD_LEFT, CMD_RIGHT, CMD_UP, CMD_DOWN, CMD_LF, CMD_SETCOL, CMD_LINEHOME, CMD_LINEEND
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_CELL   = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WRAP   = 3'd0,
		CFG_SCROLL = 3'd1,
		CFG_TAB    = 3'd2,
		CFG_TOP    = 3'd3,
		CFG_BOT    = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PUT_A, ST_PUT_B, ST_PUT_W, ST_COPY, ST_DRAIN, ST_FILL,
		ST_SW_START, ST_SWEEP, ST_SW_DRAIN, ST_CLR_REP, ST_REPORT
	} state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [CHAR_W-1:0] char_code;
		logic              target_row;
		logic [COL_W-1:0]  target_col;
		logic [COL_W-1:0]  end_col;
		logic [COL_W-1:0]  step_count;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [ROW_W-1:0]  out_row;
		logic [COL_W-1:0]  out_col;
		logic [CHAR_W-1:0] out_char;
		logic              last;
	} result_t;

endpackage

### design/text_screen_cursor_engine.sv
// Top level of the text screen cursor engine.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   command  | start / busy            | item   (item_t)
//   result   | strobe, one cycle       | result (result_t)
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// The screen and a shadow copy of what was last reported live in two cell memories.
// A cursor-only command only reports the cursor. A put or tab writes each character in turn,
// then sweeps one cell per cycle from the lowest to the highest touched cell. A scroll adds
// a copy of each frame row above the bottom, a drain and a fill of the bottom row, and widens
// the sweep; a clear line fills the row and sweeps it, a clear fills both memories and
// reports the clear. After reset a clearing pass holds busy high.
// Results cannot be stalled; config writes are taken in any cycle.
module text_screen_cursor_engine #(
	parameter int ROWS = tsce_pkg::ROWS_DEF,
	parameter int COLS = tsce_pkg::COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  tsce_pkg::item_t                 item,
	output logic                            busy,
	output logic                            strobe,
	output tsce_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsce_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsce_pkg::*;

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int KEY_W  = ROW_W + COL_W;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [ROW_W-1:0] ROWS_V   = ROW_W'(ROWS);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
	localparam logic [COL_W-1:0] COLS_V   = COL_W'(COLS);

	function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = AW'(int'(r) * COLS + int'(c));
	endfunction

	function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] r);
		sat_row = (r > LAST_ROW) ? LAST_ROW : r;
	endfunction

	function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] c);
		sat_col = (c > LAST_COL) ? LAST_COL : c;
	endfunction

	function automatic logic [KEY_W-1:0] kmin(input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b);
		kmin = (a < b) ? a : b;
	endfunction

	function automatic logic [KEY_W-1:0] kmax(input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b);
		kmax = (a > b) ? a : b;
	endfunction

	// configuration
	logic       wrap_q, scroll_q, ftop_q, fbot_q;
	logic [1:0] tab_q;

	// control and cursor
	state_t            state_q, state_d, ret_q;
	logic [ROW_W-1:0]  row_q, pr_q, er_q, cp_r_s1, sw_r_s1;
	logic [COL_W-1:0]  col_q, pc_q, ec_q, cp_c_s1, sw_c_s1;
	logic              both_q, dirty_q, cp_v_s1, sw_v_s1;
	logic [KEY_W-1:0]  lo_q, hi_q;
	logic [CHAR_W-1:0] ch_q;
	logic [3:0]        cnt_q;

	// memory ports
	logic              scr_we, shd_we;
	logic [AW-1:0]     scr_wa, shd_wa, scr_ra, shd_ra;
	logic [CHAR_W-1:0] scr_wd, shd_wd, scr_rd, shd_rd;

	// frame and step helpers
	logic [ROW_W-1:0] top, bot;
	logic             p_end, defer, past, more, scroll_copy, scroll_go, accept;

	// command decode
	logic [ROW_W-1:0] d_row, d_pr, d_er;
	logic [COL_W-1:0] d_col, d_pc, d_ec;
	logic             d_fill, d_both;
	logic [3:0]       d_cnt;
	logic [CHAR_W-1:0] d_ch;
	state_t           d_ret;
	logic [COL_W:0]   sum_c, tab_end;
	logic [COL_W:0]   sum_r, lim_r;
	logic [3:0]       ts;
	logic [ROW_W-1:0] tr, bk_r;
	logic [COL_W-1:0] bk_c, to_c;

	assign cfg_ready   = 1'b1;
	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign top         = sat_row({1'b0, ftop_q});
	assign bot         = sat_row({1'b0, fbot_q});
	assign p_end       = (pr_q == er_q) && (pc_q == ec_q);
	assign defer       = (row_q > bot);
	assign past        = (col_q >= COLS_V);
	assign more        = (cnt_q > 4'd1);
	assign scroll_copy = (top < bot);
	assign scroll_go   = (state_q == ST_PUT_A && defer) ||
		(state_q == ST_PUT_B && past && wrap_q && !(row_q < bot) && scroll_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q   <= 1'b0;
			scroll_q <= 1'b0;
			tab_q    <= 2'd2;
			ftop_q   <= 1'b0;
			fbot_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WRAP:   wrap_q   <= cfg_data[0];
				CFG_SCROLL: scroll_q <= cfg_data[0];
				CFG_TAB:    tab_q    <= cfg_data[1:0];
				CFG_TOP:    ftop_q   <= cfg_data[0];
				CFG_BOT:    fbot_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// new cursor and cell span for a command taken in idle
	always_comb begin
		d_row  = row_q;
		d_col  = col_q;
		d_fill = 1'b0;
		d_both = 1'b0;
		d_pr   = '0;
		d_pc   = '0;
		d_er   = LAST_ROW;
		d_ec   = LAST_COL;
		d_cnt  = 4'd1;
		d_ch   = item.char_code;
		d_ret  = ST_SW_START;
		tr     = sat_row({1'b0, item.target_row});
		to_c   = sat_col(item.end_col);
		sum_c  = {1'b0, col_q} + {1'b0, item.step_count};
		sum_r  = (COL_W+1)'(top) + {1'b0, item.step_count};
		lim_r  = (COL_W+1)'(row_q) + {1'b0, item.step_count};
		ts     = 4'd1 << tab_q;
		tab_end = {1'b0, col_q & ~COL_W'(ts - 4'd1)} + (COL_W+1)'(ts);
		bk_r   = row_q;
		bk_c   = col_q;
		if (col_q != '0) begin
			bk_c = col_q - 1'b1;
		end else if (row_q != '0) begin
			bk_c = LAST_COL;
			bk_r = row_q - 1'b1;
		end
		case (item.cmd)
			CMD_PUT: ;
			CMD_GOTO: begin
				d_row = tr;
				d_col = sat_col(item.target_col);
			end
			CMD_HOME: begin
				d_row = '0;
				d_col = '0;
			end
			CMD_CLEAR: begin
				d_row  = '0;
				d_col  = '0;
				d_fill = 1'b1;
				d_both = 1'b1;
				d_ret  = ST_CLR_REP;
			end
			CMD_CLRLINE: begin
				d_fill = 1'b1;
				d_pr   = tr;
				d_er   = tr;
			end
			CMD_CLRCOLS: begin
				d_fill = (item.target_col <= to_c);
				d_pr   = tr;
				d_er   = tr;
				d_pc   = item.target_col;
				d_ec   = to_c;
			end
			CMD_BKSP: begin
				d_row  = bk_r;
				d_col  = bk_c;
				d_fill = (bk_r < ROWS_V) && (bk_c < COLS_V);
				d_pr   = bk_r;
				d_er   = bk_r;
				d_pc   = bk_c;
				d_ec   = bk_c;
			end
			CMD_TAB: begin
				d_cnt = 4'(tab_end - {1'b0, col_q});
				d_ch  = SPACE_CHAR;
			end
			CMD_LEFT:     d_col = (col_q > item.step_count) ? col_q - item.step_count : '0;
			CMD_RIGHT:    d_col = (sum_c > (COL_W+1)'(LAST_COL)) ? LAST_COL : sum_c[COL_W-1:0];
			CMD_UP:       d_row = ((COL_W+1)'(row_q) < sum_r) ? top
				: ROW_W'((COL_W+1)'(row_q) - {1'b0, item.step_count});
			CMD_DOWN:     d_row = (lim_r > (COL_W+1)'(bot)) ? bot : lim_r[ROW_W-1:0];
			CMD_LF:       d_row = (row_q < ROWS_V) ? row_q + 1'b1 : row_q;
			CMD_SETCOL:   d_col = sat_col(item.target_col);
			CMD_LINEHOME: d_col = '0;
			CMD_LINEEND:  d_col = LAST_COL;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.cmd == CMD_PUT || item.cmd == CMD_TAB) begin
						state_d = ST_PUT_A;
					end else if (d_fill) begin
						state_d = ST_FILL;
					end else begin
						state_d = ST_REPORT;
					end
				end
			end
			ST_PUT_A: begin
				if (scroll_go) begin
					state_d = scroll_copy ? ST_COPY : ST_FILL;
				end else begin
					state_d = ST_PUT_B;
				end
			end
			ST_PUT_B: begin
				if (past && !wrap_q) begin
					state_d = more ? ST_PUT_A : ST_SW_START;
				end else if (scroll_go) begin
					state_d = scroll_copy ? ST_COPY : ST_FILL;
				end else begin
					state_d = ST_PUT_W;
				end
			end
			ST_PUT_W:    state_d = more ? ST_PUT_A : ST_SW_START;
			ST_COPY:     state_d = p_end ? ST_DRAIN : ST_COPY;
			ST_DRAIN:    state_d = ST_FILL;
			ST_FILL:     state_d = p_end ? ret_q : ST_FILL;
			ST_SW_START: state_d = dirty_q ? ST_SWEEP : ST_REPORT;
			ST_SWEEP:    state_d = p_end ? ST_SW_DRAIN : ST_SWEEP;
			ST_SW_DRAIN: state_d = ST_REPORT;
			ST_CLR_REP:  state_d = ST_REPORT;
			ST_REPORT:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		scr_we = 1'b0;
		scr_wa = cell_addr(pr_q, pc_q);
		scr_wd = SPACE_CHAR;
		shd_we = 1'b0;
		shd_wa = cell_addr(pr_q, pc_q);
		shd_wd = SPACE_CHAR;
		scr_ra = cell_addr(pr_q, pc_q);
		shd_ra = cell_addr(pr_q, pc_q);
		if (state_q == ST_COPY) begin
			scr_ra = cell_addr(pr_q + 1'b1, pc_q);
		end
		if (cp_v_s1) begin
			scr_we = 1'b1;
			scr_wa = cell_addr(cp_r_s1, cp_c_s1);
			scr_wd = scr_rd;
		end else if (state_q == ST_FILL) begin
			scr_we = 1'b1;
			shd_we = both_q;
		end else if (state_q == ST_PUT_W) begin
			scr_we = 1'b1;
			scr_wa = cell_addr(row_q, col_q);
			scr_wd = ch_q;
		end
		if (sw_v_s1 && scr_rd != shd_rd) begin
			shd_we = 1'b1;
			shd_wa = cell_addr(sw_r_s1, sw_c_s1);
			shd_wd = scr_rd;
		end
	end

	tsce_cellram #(.DEPTH(NCELLS), .AW(AW)) u_screen (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_wa),
		.wdata (scr_wd),
		.raddr (scr_ra),
		.rdata (scr_rd)
	);

	tsce_cellram #(.DEPTH(NCELLS), .AW(AW)) u_shadow (
		.clk   (clk),
		.we    (shd_we),
		.waddr (shd_wa),
		.wdata (shd_wd),
		.raddr (shd_ra),
		.rdata (shd_rd)
	);

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			ret_q   <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			pr_q    <= '0;
			pc_q    <= '0;
			er_q    <= LAST_ROW;
			ec_q    <= LAST_COL;
			both_q  <= 1'b1;
			dirty_q <= 1'b0;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			cp_r_s1 <= '0;
			cp_c_s1 <= '0;
			sw_r_s1 <= '0;
			sw_c_s1 <= '0;
			cp_v_s1 <= 1'b0;
			sw_v_s1 <= 1'b0;
			strobe  <= 1'b0;
			result  <= '0;
		end else begin
			state_q <= state_d;
			cp_v_s1 <= (state_q == ST_COPY);
			sw_v_s1 <= (state_q == ST_SWEEP);
			strobe  <= 1'b0;

			// advance the span pointer in row-major order
			if (state_q == ST_COPY || state_q == ST_FILL || state_q == ST_SWEEP) begin
				if (pc_q == LAST_COL) begin
					pc_q <= '0;
					pr_q <= pr_q + 1'b1;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q   <= d_row;
						col_q   <= d_col;
						pr_q    <= d_pr;
						pc_q    <= d_pc;
						er_q    <= d_er;
						ec_q    <= d_ec;
						both_q  <= d_both;
						ret_q   <= d_ret;
						cnt_q   <= d_cnt;
						dirty_q <= d_fill && !d_both;
						lo_q    <= {d_pr, d_pc};
						hi_q    <= {d_er, d_ec};
					end
				end
				ST_PUT_A: begin
					if (defer) begin
						row_q <= bot;
					end
				end
				ST_PUT_B: begin
					if (past) begin
						if (!wrap_q) begin
							cnt_q <= cnt_q - 1'b1;
						end else begin
							col_q <= '0;
							if (row_q < bot) begin
								row_q <= row_q + 1'b1;
							end
						end
					end
				end
				ST_PUT_W: begin
					col_q   <= col_q + 1'b1;
					cnt_q   <= cnt_q - 1'b1;
					dirty_q <= 1'b1;
					lo_q    <= dirty_q ? kmin(lo_q, {row_q, col_q}) : {row_q, col_q};
					hi_q    <= dirty_q ? kmax(hi_q, {row_q, col_q}) : {row_q, col_q};
				end
				ST_DRAIN: begin
					pr_q <= bot;
					pc_q <= '0;
					er_q <= bot;
					ec_q <= LAST_COL;
				end
				ST_SW_START: begin
					{pr_q, pc_q} <= lo_q;
					{er_q, ec_q} <= hi_q;
				end
				ST_CLR_REP: begin
					strobe <= 1'b1;
					result <= '{kind: KIND_CLEAR, out_row: '0, out_col: '0,
						out_char: '0, last: 1'b0};
				end
				ST_REPORT: begin
					strobe <= 1'b1;
					result <= '{kind: KIND_CURSOR, out_row: row_q, out_col: col_q,
						out_char: '0, last: 1'b1};
				end
				default: ;
			endcase

			// scroll: copy rows up when the frame spans rows, then blank the bottom row
			if (scroll_go) begin
				ret_q   <= (state_q == ST_PUT_A) ? ST_PUT_B : ST_PUT_W;
				both_q  <= 1'b0;
				pc_q    <= '0;
				ec_q    <= LAST_COL;
				pr_q    <= scroll_copy ? top : bot;
				er_q    <= scroll_copy ? bot - 1'b1 : bot;
				dirty_q <= 1'b1;
				lo_q    <= dirty_q ? kmin(lo_q, {(scroll_copy ? top : bot), COL_W'(0)})
					: {(scroll_copy ? top : bot), COL_W'(0)};
				hi_q    <= dirty_q ? kmax(hi_q, {bot, LAST_COL}) : {bot, LAST_COL};
			end

			if (state_q == ST_COPY) begin
				cp_r_s1 <= pr_q;
				cp_c_s1 <= pc_q;
			end
			if (state_q == ST_SWEEP) begin
				sw_r_s1 <= pr_q;
				sw_c_s1 <= pc_q;
			end
			if (sw_v_s1 && scr_rd != shd_rd) begin
				strobe <= 1'b1;
				result <= '{kind: KIND_CELL, out_row: sw_r_s1, out_col: sw_c_s1,
					out_char: scr_rd, last: 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			ch_q <= d_ch;
		end
	end

endmodule

### design/tsce_cellram.sv
// Character cell memory: one write port, one registered read port.
module tsce_cellram #(
	parameter int DEPTH = tsce_pkg::ROWS_DEF * tsce_pkg::COLS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tsce_pkg::CHAR_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [tsce_pkg::CHAR_W-1:0] rdata
);
	import tsce_pkg::*;

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/tsce_checker.sv
// Port-level checker for the text screen cursor engine, bound to the top level.
module tsce_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input tsce_pkg::result_t result
);
	import tsce_pkg::*;

	a_last_is_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> result.kind == KIND_CURSOR)
		else $error("last transaction is not a cursor report");

	a_cursor_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_CURSOR |-> result.last)
		else $error("cursor report not marked last");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_clear_then_home: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_CLEAR |=> strobe && result.kind == KIND_CURSOR
			&& result.out_row == '0 && result.out_col == '0)
		else $error("clear not followed by home cursor report");

	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("final report while still busy");

endmodule

bind text_screen_cursor_engine tsce_checker u_tsce_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
